FILE: rtl/core/ilir_pkg.sv
`default_nettype none

package ilir_pkg;

  localparam int DEPTH_DEF       = 64;
  localparam int VALUE_WIDTH_DEF = 32;

  // fixed field widths on the stream ports
  localparam int VALUE_PORT_W = 32;
  localparam int DATA_OUT_W   = 32;
  localparam int OP_W         = 2;
  localparam int STATUS_W     = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_WRITE  = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  // per-beat shift/write command broadcast to the cell chain
  typedef struct packed {
    logic ins;  // cells above idx take the left neighbor
    logic rem;  // cells at or above idx take the right neighbor
    logic wr;   // cell at idx loads the new value
  } ilir_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/core/indexed_list_insert_remove_top.sv
// Indexed list with insert/remove shifting and an emulated capacity.
// Input stream (s_axis): one beat is one request; tuser carries the op
// (insert, remove, read, overwrite/append), tdata the index and value.
// Output stream (m_axis): one beat per request with the removed, read or
// replaced entry, the count and capacity after the request (tdata) and a
// status code (tuser): ok, index out of range, store full, list empty.
// Entries live in a row of DEPTH cells; on an insert every cell above the
// index takes its left neighbor, on a remove each cell at or above it its
// right neighbor, all in the same clock, so a request is done in the cycle it is accepted.
// The result beat is registered and valid the cycle after the request beat.
// Throughput: one request per cycle while m_axis_tready is high.
// If the receiver stalls, the result waits in the output register and
// s_axis_tready drops until that beat is taken.
// Reset empties the list (count 0, capacity 1); entry contents are not
// cleared and are only ever read below the count.
`default_nettype none

module indexed_list_insert_remove_top #(
  parameter  int DEPTH       = ilir_pkg::DEPTH_DEF,
  parameter  int VALUE_WIDTH = ilir_pkg::VALUE_WIDTH_DEF,
  localparam int CNT_W       = $clog2(DEPTH + 1),
  localparam int S_USED      = CNT_W + ilir_pkg::VALUE_PORT_W,
  localparam int S_TDATA_W   = ((S_USED + 7) / 8) * 8,
  localparam int M_USED      = ilir_pkg::DATA_OUT_W + 2 * CNT_W,
  localparam int M_TDATA_W   = ((M_USED + 7) / 8) * 8
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [S_TDATA_W-1:0]            s_axis_tdata,  // index, value
  input  wire logic [ilir_pkg::OP_W-1:0]       s_axis_tuser,  // op
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [M_TDATA_W-1:0]                 m_axis_tdata,  // data_out, count, capacity_now
  output logic [ilir_pkg::STATUS_W-1:0]        m_axis_tuser   // status
);

  logic                                acc;
  logic [CNT_W-1:0]                    idx;
  logic [ilir_pkg::VALUE_PORT_W-1:0]   value_in;
  logic [VALUE_WIDTH-1:0]              value_st;
  ilir_pkg::ilir_cmd_t                 cmd;
  logic [VALUE_WIDTH-1:0]              q    [DEPTH];
  logic [VALUE_WIDTH-1:0]              rd   [DEPTH];
  logic [VALUE_WIDTH-1:0]              rd_all;
  logic [ilir_pkg::DATA_OUT_W-1:0]     data_out;
  logic [CNT_W-1:0]                    count;
  logic [CNT_W-1:0]                    cap;
  logic                                m_valid;

  assign s_axis_tready = !m_valid || m_axis_tready;
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign idx           = s_axis_tdata[CNT_W-1:0];
  assign value_in      = s_axis_tdata[S_USED-1:CNT_W];
  assign value_st      = VALUE_WIDTH'(value_in);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] left;
    logic [VALUE_WIDTH-1:0] right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = q[i+1];
    end
    ilir_cell #(
      .POS   (i),
      .CNT_W (CNT_W),
      .VW    (VALUE_WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .idx_i   (idx),
      .value_i (value_st),
      .left_i  (left),
      .right_i (right),
      .q_o     (q[i]),
      .rd_o    (rd[i])
    );
  end

  // at most one cell drives a nonzero word
  always_comb begin
    rd_all = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_all = rd_all | rd[i];
    end
  end

  ilir_ctrl #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W),
    .VW    (VALUE_WIDTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (acc),
    .op_i       (s_axis_tuser),
    .idx_i      (idx),
    .rd_i       (rd_all),
    .m_ready_i  (m_axis_tready),
    .cmd_o      (cmd),
    .m_valid_o  (m_valid),
    .data_out_o (data_out),
    .count_o    (count),
    .cap_o      (cap),
    .status_o   (m_axis_tuser)
  );

  assign m_axis_tvalid = m_valid;

  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[M_USED-1:0] = {cap, count, data_out};
  end

endmodule

`default_nettype wire

FILE: rtl/core/ilir_cell.sv
`default_nettype none

module ilir_cell #(
  parameter int POS   = 0,
  parameter int CNT_W = 7,
  parameter int VW    = 32
) (
  input  wire logic               clk_i,
  input  wire ilir_pkg::ilir_cmd_t cmd_i,
  input  wire logic [CNT_W-1:0]   idx_i,
  input  wire logic [VW-1:0]      value_i,
  input  wire logic [VW-1:0]      left_i,
  input  wire logic [VW-1:0]      right_i,
  output logic      [VW-1:0]      q_o,
  output logic      [VW-1:0]      rd_o
);

  localparam logic [CNT_W-1:0] MY_POS = CNT_W'(POS);

  logic [VW-1:0] entry_q;
  logic [VW-1:0] entry_d;
  logic          hit;
  logic          above;

  assign hit   = (idx_i == MY_POS);
  assign above = (MY_POS > idx_i);

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.wr && hit) begin
      entry_d = value_i;
    end else if (cmd_i.ins && above) begin
      entry_d = left_i;
    end else if (cmd_i.rem && (above || hit)) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign q_o  = entry_q;
  // one-hot contribution to the read bus
  assign rd_o = hit ? entry_q : '0;

endmodule

`default_nettype wire

FILE: rtl/core/ilir_ctrl.sv
`default_nettype none

module ilir_ctrl #(
  parameter int DEPTH = ilir_pkg::DEPTH_DEF,
  parameter int CNT_W = 7,
  parameter int VW    = ilir_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          acc_i,
  input  wire logic [ilir_pkg::OP_W-1:0]     op_i,
  input  wire logic [CNT_W-1:0]              idx_i,
  input  wire logic [VW-1:0]                 rd_i,
  input  wire logic                          m_ready_i,
  output ilir_pkg::ilir_cmd_t                cmd_o,
  output logic                               m_valid_o,
  output logic [ilir_pkg::DATA_OUT_W-1:0]    data_out_o,
  output logic [CNT_W-1:0]                   count_o,
  output logic [CNT_W-1:0]                   cap_o,
  output logic [ilir_pkg::STATUS_W-1:0]      status_o
);

  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);
  localparam logic [CNT_W:0]   DEPTH_C1 = (CNT_W+1)'(DEPTH);
  localparam logic [CNT_W-1:0] ONE_C    = CNT_W'(1);

  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] cap_q, cap_d;
  logic             m_valid_q;
  logic [ilir_pkg::DATA_OUT_W-1:0] data_q, data_d;
  ilir_pkg::status_e status_q, status_d;

  ilir_pkg::ilir_cmd_t cmd;
  ilir_pkg::op_e       op;
  logic [CNT_W:0]      cap_x2;
  logic [CNT_W-1:0]    cap_grown;
  logic [CNT_W-1:0]    cnt_dec;
  logic [CNT_W-1:0]    cap_shrunk;
  logic                full;

  assign op      = ilir_pkg::op_e'(op_i);
  assign full    = (count_q == DEPTH_C);
  assign cap_x2  = {cap_q, 1'b0};
  assign cnt_dec = count_q - ONE_C;

  // doubling on a full list, clamped to the store size
  always_comb begin
    if (count_q != cap_q) begin
      cap_grown = cap_q;
    end else if (cap_x2 > DEPTH_C1) begin
      cap_grown = DEPTH_C;
    end else begin
      cap_grown = cap_x2[CNT_W-1:0];
    end
  end

  // halving when under a quarter used after the remove, one if that empties it; floor of one
  always_comb begin
    cap_shrunk = cap_q;
    if (cnt_dec < (cap_q >> 2)) begin
      if ((cnt_dec == '0) || ((cap_q >> 1) == '0)) begin
        cap_shrunk = ONE_C;
      end else begin
        cap_shrunk = cap_q >> 1;
      end
    end
  end

  always_comb begin
    cmd      = '0;
    count_d  = count_q;
    cap_d    = cap_q;
    data_d   = '0;
    status_d = ilir_pkg::ST_OK;
    case (op)
      ilir_pkg::OP_INSERT: begin
        if (idx_i > count_q) begin
          status_d = ilir_pkg::ST_RANGE;
        end else if (full) begin
          status_d = ilir_pkg::ST_FULL;
        end else begin
          cmd.ins = 1'b1;
          cmd.wr  = 1'b1;
          count_d = count_q + ONE_C;
          cap_d   = cap_grown;
        end
      end
      ilir_pkg::OP_REMOVE: begin
        if (count_q == '0) begin
          status_d = ilir_pkg::ST_EMPTY;
        end else if (idx_i >= count_q) begin
          status_d = ilir_pkg::ST_RANGE;
        end else begin
          cmd.rem = 1'b1;
          data_d  = ilir_pkg::DATA_OUT_W'(rd_i);
          count_d = cnt_dec;
          cap_d   = cap_shrunk;
        end
      end
      ilir_pkg::OP_READ: begin
        if (idx_i >= count_q) begin
          status_d = ilir_pkg::ST_RANGE;
        end else begin
          data_d = ilir_pkg::DATA_OUT_W'(rd_i);
        end
      end
      ilir_pkg::OP_WRITE: begin
        if (idx_i < count_q) begin
          cmd.wr = 1'b1;
          data_d = ilir_pkg::DATA_OUT_W'(rd_i);
        end else if (idx_i == count_q) begin
          if (full) begin
            status_d = ilir_pkg::ST_FULL;
          end else begin
            cmd.wr  = 1'b1;
            count_d = count_q + ONE_C;
            cap_d   = cap_grown;
          end
        end else begin
          status_d = ilir_pkg::ST_RANGE;
        end
      end
      default: begin
        status_d = ilir_pkg::ST_RANGE;
      end
    endcase
  end

  assign cmd_o = acc_i ? cmd : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      cap_q     <= ONE_C;
      m_valid_q <= 1'b0;
    end else begin
      if (acc_i) begin
        count_q   <= count_d;
        cap_q     <= cap_d;
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      data_q   <= data_d;
      status_q <= status_d;
    end
  end

  assign m_valid_o  = m_valid_q;
  assign data_out_o = data_q;
  assign count_o    = count_q;
  assign cap_o      = cap_q;
  assign status_o   = status_q;

`ifndef SYNTHESIS
  a_count_le_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cap_q)
    else $error("entry count above capacity");

  a_cap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cap_q != '0) && (cap_q <= DEPTH_C))
    else $error("capacity out of range");

  a_err_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && (status_d != ilir_pkg::ST_OK) |=> $stable(count_q) && $stable(cap_q))
    else $error("failed request changed state");

  a_remove_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && cmd.rem |=> count_q == $past(count_q) - ONE_C)
    else $error("remove did not drop the count");
`endif

endmodule

`default_nettype wire

FILE: tb/indexed_list_insert_remove_top_tb.sv
module indexed_list_insert_remove_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_DEPTH   = 64;
  localparam int IDX_W        = 7;
  localparam int S_W          = 40;
  localparam int M_W          = 48;
  localparam int RANDOM_ITEMS = 1450;
  localparam int QUIET_ITEMS  = 200;
  localparam int LONG_STALL   = 80;

  typedef struct packed {
    logic [ilir_pkg::DATA_OUT_W-1:0] data;
    logic [IDX_W-1:0]                cnt;
    logic [IDX_W-1:0]                cap;
    ilir_pkg::status_e               status;
  } list_result_t;

  // shadow copy of the list plus the queue of results it predicts
  class list_shadow;
    logic [ilir_pkg::VALUE_PORT_W-1:0] cells [LIST_DEPTH];
    int unsigned used;
    int unsigned cap;
    int unsigned mismatches;
    int unsigned beats;
    list_result_t expected_q[$];

    function new();
      used = 0;
      cap = 1;
      mismatches = 0;
      beats = 0;
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    // grow first if full, then open a slot at pos
    function void place(int unsigned pos, logic [ilir_pkg::VALUE_PORT_W-1:0] v);
      int unsigned k;
      if (used == cap) cap = (cap * 2 > LIST_DEPTH) ? LIST_DEPTH : cap * 2;
      for (k = used; k > pos; k--) cells[k] = cells[k-1];
      cells[pos] = v;
      used++;
    endfunction

    function void note_request(ilir_pkg::op_e op, int unsigned idx,
                               logic [ilir_pkg::VALUE_PORT_W-1:0] v);
      list_result_t r;
      int unsigned k;
      r.data = '0;
      r.status = ilir_pkg::ST_OK;
      case (op)
        ilir_pkg::OP_INSERT: begin
          if (idx > used) r.status = ilir_pkg::ST_RANGE;
          else if (used >= LIST_DEPTH) r.status = ilir_pkg::ST_FULL;
          else place(idx, v);
        end
        ilir_pkg::OP_REMOVE: begin
          if (used == 0) r.status = ilir_pkg::ST_EMPTY;
          else if (idx >= used) r.status = ilir_pkg::ST_RANGE;
          else begin
            r.data = cells[idx];
            for (k = idx; k + 1 < used; k++) cells[k] = cells[k+1];
            used--;
            if (used < cap / 4) cap = (used == 0 || cap / 2 == 0) ? 1 : cap / 2;
          end
        end
        ilir_pkg::OP_READ: begin
          if (idx >= used) r.status = ilir_pkg::ST_RANGE;
          else r.data = cells[idx];
        end
        default: begin
          if (idx < used) begin
            r.data = cells[idx];
            cells[idx] = v;
          end else if (idx == used) begin
            if (used >= LIST_DEPTH) r.status = ilir_pkg::ST_FULL;
            else place(idx, v);
          end else begin
            r.status = ilir_pkg::ST_RANGE;
          end
        end
      endcase
      r.cnt = used[IDX_W-1:0];
      r.cap = cap[IDX_W-1:0];
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [M_W-1:0] tdata,
                               logic [ilir_pkg::STATUS_W-1:0] tuser);
      list_result_t want;
      beats++;
      if (expected_q.size() == 0) begin
        flag($sformatf("beat %0d: result with no request outstanding", beats));
        return;
      end
      want = expected_q.pop_front();
      if (tdata[31:0] !== want.data)
        flag($sformatf("beat %0d: data_out expected %h got %h", beats, want.data, tdata[31:0]));
      if (tdata[38:32] !== want.cnt)
        flag($sformatf("beat %0d: count expected %0d got %0d", beats, want.cnt, tdata[38:32]));
      if (tdata[45:39] !== want.cap)
        flag($sformatf("beat %0d: capacity expected %0d got %0d", beats, want.cap,
                       tdata[45:39]));
      if (tuser !== want.status)
        flag($sformatf("beat %0d: status expected %0d got %0d", beats, want.status, tuser));
    endfunction
  endclass

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [S_W-1:0]                s_axis_tdata;   // index[6:0], value[38:7], zero pad
  logic [ilir_pkg::OP_W-1:0]     s_axis_tuser;   // op
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [M_W-1:0]                m_axis_tdata;   // data_out, count, capacity_now
  logic [ilir_pkg::STATUS_W-1:0] m_axis_tuser;   // status

  list_shadow shadow;
  bit quiet_tail = 1'b0;
  bit rx_idle_on = 1'b0;
  bit stall_req  = 1'b0;

  indexed_list_insert_remove_top uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
        shadow.check_result(m_axis_tdata, m_axis_tuser);
      if (s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1)
        shadow.note_request(ilir_pkg::op_e'(s_axis_tuser), 32'(s_axis_tdata[6:0]),
                            s_axis_tdata[38:7]);
    end
  end

  // result sink: random back-pressure bursts, plus one long hold on request
  initial begin : result_sink
    forever begin
      @(negedge clk_i);
      if (stall_req) begin
        stall_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_STALL - 1) @(negedge clk_i);
      end else if (!quiet_tail && rx_idle_on && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 13) - 1) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // called at a falling edge; returns at the falling edge after the beat is taken
  task automatic drive_req(ilir_pkg::op_e op, logic [IDX_W-1:0] idx, logic [31:0] v);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {1'b0, v, idx};
    @(posedge clk_i);
    while (s_axis_tready !== 1'b1) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic hold_off(int unsigned n);
    s_axis_tvalid <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (shadow.expected_q.size() != 0) @(negedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned sent;
    int unsigned phase;
    int unsigned plen;
    int unsigned n;
    int unsigned mode;
    int unsigned r;
    int unsigned used;
    bit tx_idle_on;
    ilir_pkg::op_e op;
    logic [IDX_W-1:0] idx;
    logic [31:0] v;

    shadow = new();
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: empty-list errors, small shrink, front/middle/end inserts
    drive_req(ilir_pkg::OP_READ,   7'd0,  32'h0000_0000);
    drive_req(ilir_pkg::OP_REMOVE, 7'd0,  32'h0000_0000);
    drive_req(ilir_pkg::OP_INSERT, 7'd1,  32'h1111_1111);
    drive_req(ilir_pkg::OP_WRITE,  7'd64, 32'hFFFF_FFFF);
    drive_req(ilir_pkg::OP_INSERT, 7'd0,  32'hFFFF_FFFF);
    drive_req(ilir_pkg::OP_WRITE,  7'd1,  32'h0000_0000);  // append, capacity 1 -> 2
    drive_req(ilir_pkg::OP_REMOVE, 7'd0,  32'h0);
    drive_req(ilir_pkg::OP_REMOVE, 7'd0,  32'h0);          // empty but capacity stays 2
    drive_req(ilir_pkg::OP_INSERT, 7'd0,  32'hA5A5_0001);
    drive_req(ilir_pkg::OP_INSERT, 7'd0,  32'h5A5A_0002);
    drive_req(ilir_pkg::OP_INSERT, 7'd2,  32'hDEAD_0003);
    drive_req(ilir_pkg::OP_INSERT, 7'd1,  32'hBEEF_0004);
    drive_req(ilir_pkg::OP_WRITE,  7'd4,  32'h8000_0005);  // append, capacity 4 -> 8
    drive_req(ilir_pkg::OP_WRITE,  7'd2,  32'h7FFF_FFFF);
    drive_req(ilir_pkg::OP_READ,   7'd4,  32'h0);
    drive_req(ilir_pkg::OP_READ,   7'd5,  32'h0);
    drive_req(ilir_pkg::OP_REMOVE, 7'd5,  32'h0);
    drive_req(ilir_pkg::OP_WRITE,  7'd6,  32'h0);
    drive_req(ilir_pkg::OP_REMOVE, 7'd2,  32'h0);
    drive_req(ilir_pkg::OP_REMOVE, 7'd0,  32'h0);
    drive_req(ilir_pkg::OP_REMOVE, 7'd2,  32'h0);
    drive_req(ilir_pkg::OP_REMOVE, 7'd0,  32'h0);          // shrink 8 -> 4
    drive_req(ilir_pkg::OP_REMOVE, 7'd0,  32'h0);          // empty -> capacity 1
    drive_req(ilir_pkg::OP_INSERT, 7'd64, 32'h0);
    drive_req(ilir_pkg::OP_READ,   7'd0,  32'h0);

    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      mode = $urandom_range(0, 9);
      // 0..3 fill, 4..6 drain, 7..8 mixed, 9 noise
      plen = (mode == 9) ? $urandom_range(5, 20) : $urandom_range(30, 110);
      tx_idle_on = $urandom_range(0, 3) != 0;
      rx_idle_on = $urandom_range(0, 3) != 0;
      if (phase == 2) stall_req = 1'b1;
      for (n = 0; n < plen && sent < RANDOM_ITEMS; n++) begin
        if (sent >= RANDOM_ITEMS - QUIET_ITEMS) quiet_tail = 1'b1;
        used = shadow.used;
        r = $urandom_range(0, 99);
        if (mode <= 3) begin
          op = (r < 55) ? ilir_pkg::OP_INSERT : (r < 85) ? ilir_pkg::OP_WRITE :
               (r < 95) ? ilir_pkg::OP_READ : ilir_pkg::OP_REMOVE;
        end else if (mode <= 6) begin
          op = (r < 70) ? ilir_pkg::OP_REMOVE : (r < 80) ? ilir_pkg::OP_INSERT :
               (r < 90) ? ilir_pkg::OP_READ : ilir_pkg::OP_WRITE;
        end else begin
          op = ilir_pkg::op_e'(r[1:0]);
        end
        if (mode == 9 || $urandom_range(0, 9) == 0) begin
          idx = IDX_W'($urandom_range(0, LIST_DEPTH));
        end else if (op == ilir_pkg::OP_REMOVE || op == ilir_pkg::OP_READ) begin
          idx = (used == 0) ? 7'd0 : IDX_W'($urandom_range(0, used - 1));
        end else if (op == ilir_pkg::OP_WRITE && mode <= 3) begin
          idx = used[IDX_W-1:0];                 // append while filling
        end else begin
          idx = IDX_W'($urandom_range(0, used));
        end
        r = $urandom_range(0, 9);
        v = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
        if (!quiet_tail && tx_idle_on && $urandom_range(0, 5) == 0)
          hold_off($urandom_range(1, 13));
        drive_req(op, idx, v);
        sent++;
      end
      if (phase % 4 == 1) begin
        hold_off(1);
        wait_drained();
      end
      phase++;
    end

    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (4) @(posedge clk_i);
    if (shadow.mismatches == 0 && shadow.expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
